// ----- hdl/slcs_pkg.sv -----
// Package for the squelch-lock channel scanner.
// Holds the register map, reset values, opcodes, event codes, FSM states and the
// controller/datapath command and status types. Depends on nothing.
package slcs_pkg;

  localparam int MAX_CHANNELS_DEF = 256;

  localparam int FREQ_W   = 30;
  localparam int STEP_W   = 20;
  localparam int DBM_W    = 8;
  localparam int MS_W     = 16;
  localparam int TIME_W   = 32;
  localparam int HIT_W    = 16;
  localparam int OUT_IDX_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 30;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_FREQ = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_FREQ   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUELCH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HANG       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd6;

  // reset values
  localparam logic [FREQ_W-1:0]        START_FREQ_RST = 30'd430000000;
  localparam logic [FREQ_W-1:0]        END_FREQ_RST   = 30'd440000000;
  localparam logic [STEP_W-1:0]        STEP_RST       = 20'd12500;
  localparam logic signed [DBM_W-1:0]  SQUELCH_RST    = -8'sd90;
  localparam logic [MS_W-1:0]          DWELL_RST      = 16'd50;
  localparam logic [MS_W-1:0]          HANG_RST       = 16'd2000;

  // zero spacing falls back to this
  localparam logic [STEP_W-1:0] STEP_FALLBACK = 20'd12500;

  localparam logic [HIT_W-1:0] HIT_MAX = 16'hFFFF;

  // opcodes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_REPLY   = 2'd1;
  localparam logic [1:0] OP_REBUILD = 2'd2;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_QUIET    = 3'd1,
    EV_ACQUIRED = 3'd2,
    EV_REFRESH  = 3'd3,
    EV_RELEASED = 3'd4,
    EV_REBUILT  = 3'd5
  } event_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_TICK,
    ST_REPLY,
    ST_WIPE,
    ST_DONE
  } scan_state_t;

  typedef struct packed {
    logic accept;
    logic start_tick;
    logic start_rebuild;
    logic tick_step;
    logic reply_step;
    logic clr_step;
    logic load_out;
  } slcs_cmd_t;

  typedef struct packed {
    logic awaiting;
    logic clr_last;
  } slcs_sts_t;

endpackage

// ----- hdl/squelch_lock_channel_scanner.sv -----
// Squelch-lock channel scanner. Each item takes one pass through a small controller:
// a tick multiplies the index by the step, then adds and compares against the end
// frequency, then loads the output; an RSSI reply reads the stores, then does a
// read-modify-write of the hit and activity stores, then loads the output; a stray
// reply or unknown opcode goes straight to the output load; a rebuild sweeps both
// stores one entry per cycle, then loads the output. After reset the same sweep covers
// all MAX_CHANNELS_P entries before the first item is taken; configuration writes are
// taken at all times. A finished result sits in the output register while the next
// item is accepted. Depends on slcs_pkg, slcs_ctrl and slcs_dpath.
module squelch_lock_channel_scanner #(
  parameter int MAX_CHANNELS_P = slcs_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [slcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slcs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  logic [1:0]                          opcode,
  input  logic signed [slcs_pkg::DBM_W-1:0]   rssi_dbm,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic                                request_valid,
  output logic [slcs_pkg::OUT_IDX_W-1:0]      request_index,
  output logic [slcs_pkg::FREQ_W-1:0]         request_freq_hz,
  output logic                                is_locked,
  output logic [slcs_pkg::OUT_IDX_W-1:0]      locked_index,
  output logic [2:0]                          event_code,
  output logic [slcs_pkg::HIT_W-1:0]          hit_total
);

  slcs_pkg::slcs_cmd_t cmd;
  slcs_pkg::slcs_sts_t sts;

  assign cfg_ready = 1'b1;

  slcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .opcode    (opcode),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  slcs_dpath #(
    .MAX_CHANNELS_P (MAX_CHANNELS_P)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .rssi_dbm        (rssi_dbm),
    .request_valid   (request_valid),
    .request_index   (request_index),
    .request_freq_hz (request_freq_hz),
    .is_locked       (is_locked),
    .locked_index    (locked_index),
    .event_code      (event_code),
    .hit_total       (hit_total)
  );

endmodule

// ----- hdl/slcs_ctrl.sv -----
// Controller of the squelch-lock channel scanner: state machine and result valid.
// Drives datapath commands and the input stall. Depends on slcs_pkg.
module slcs_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  logic [1:0]             opcode,
  output logic                   res_valid,
  input  logic                   res_stall,
  output slcs_pkg::slcs_cmd_t    cmd,
  input  slcs_pkg::slcs_sts_t    sts
);

  slcs_pkg::scan_state_t state;
  slcs_pkg::scan_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slcs_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd_stall  = 1'b1;
    case (state)
      slcs_pkg::ST_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = slcs_pkg::ST_IDLE;
      end
      slcs_pkg::ST_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          cmd.accept = 1'b1;
          case (opcode)
            slcs_pkg::OP_TICK: begin
              cmd.start_tick = 1'b1;
              state_next     = slcs_pkg::ST_TICK;
            end
            slcs_pkg::OP_REPLY: begin
              state_next = sts.awaiting ? slcs_pkg::ST_REPLY : slcs_pkg::ST_DONE;
            end
            slcs_pkg::OP_REBUILD: begin
              cmd.start_rebuild = 1'b1;
              state_next        = slcs_pkg::ST_WIPE;
            end
            default: begin
              state_next = slcs_pkg::ST_DONE;
            end
          endcase
        end
      end
      slcs_pkg::ST_TICK: begin
        cmd.tick_step = 1'b1;
        state_next    = slcs_pkg::ST_DONE;
      end
      slcs_pkg::ST_REPLY: begin
        cmd.reply_step = 1'b1;
        state_next     = slcs_pkg::ST_DONE;
      end
      slcs_pkg::ST_WIPE: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = slcs_pkg::ST_DONE;
      end
      slcs_pkg::ST_DONE: begin
        if (!res_valid || !res_stall) begin
          cmd.load_out = 1'b1;
          state_next   = slcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = slcs_pkg::ST_INIT;
      end
    endcase
  end

endmodule

// ----- hdl/slcs_dpath.sv -----
// Datapath of the squelch-lock channel scanner: registers, scan state, channel
// arithmetic, hit and activity stores, result and output registers. Depends on slcs_pkg.
module slcs_dpath #(
  parameter int MAX_CHANNELS_P = slcs_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  slcs_pkg::slcs_cmd_t                     cmd,
  output slcs_pkg::slcs_sts_t                     sts,
  input  logic                                    cfg_we,
  input  logic [slcs_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [slcs_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic signed [slcs_pkg::DBM_W-1:0]       rssi_dbm,
  output logic                                    request_valid,
  output logic [slcs_pkg::OUT_IDX_W-1:0]          request_index,
  output logic [slcs_pkg::FREQ_W-1:0]             request_freq_hz,
  output logic                                    is_locked,
  output logic [slcs_pkg::OUT_IDX_W-1:0]          locked_index,
  output logic [2:0]                              event_code,
  output logic [slcs_pkg::HIT_W-1:0]              hit_total
);

  localparam int IDX_W   = $clog2(MAX_CHANNELS_P);
  localparam int NX_W    = IDX_W + 1;
  localparam int PROD_W  = NX_W + slcs_pkg::STEP_W;
  localparam int SUM_W   = (PROD_W > slcs_pkg::FREQ_W ? PROD_W : slcs_pkg::FREQ_W) + 1;
  localparam int EXT_W   = (IDX_W > slcs_pkg::OUT_IDX_W) ? IDX_W : slcs_pkg::OUT_IDX_W;
  localparam int FREQ_W  = slcs_pkg::FREQ_W;
  localparam int TIME_W  = slcs_pkg::TIME_W;
  localparam int HIT_W   = slcs_pkg::HIT_W;
  localparam int MS_W    = slcs_pkg::MS_W;

  // configuration
  logic [FREQ_W-1:0]                start_freq;
  logic [FREQ_W-1:0]                end_freq;
  logic [slcs_pkg::STEP_W-1:0]      step;
  logic signed [slcs_pkg::DBM_W-1:0] squelch;
  logic [MS_W-1:0]                  dwell;
  logic [MS_W-1:0]                  hang;
  logic                             scan_en;

  // scan state
  logic [TIME_W-1:0] now_ms;
  logic [TIME_W-1:0] last_req_ms;
  logic [IDX_W-1:0]  cur_idx;
  logic [FREQ_W-1:0] cur_freq;
  logic              lock;
  logic [IDX_W-1:0]  held_idx;
  logic [FREQ_W-1:0] held_freq;
  logic              awaiting;

  // working registers
  logic [NX_W-1:0]   nx;
  logic [PROD_W-1:0] prod;
  logic              loud;
  logic [IDX_W-1:0]  clr_addr;

  // stores
  logic [TIME_W-1:0] act_mem [MAX_CHANNELS_P];
  logic [HIT_W-1:0]  hit_mem [MAX_CHANNELS_P];
  logic [TIME_W-1:0] act_rd;
  logic [HIT_W-1:0]  hit_rd;

  // result under construction
  logic                   res_rv;
  logic [IDX_W-1:0]       res_ri;
  logic [FREQ_W-1:0]      res_rf;
  slcs_pkg::event_t       res_ev;
  logic [HIT_W-1:0]       res_hits;

  logic [slcs_pkg::STEP_W-1:0] eff_step;
  logic [NX_W-1:0]             nx_now;
  logic [SUM_W-1:0]            sum;
  logic                        nx_ok;
  logic                        go;
  logic [TIME_W-1:0]           age;
  logic                        expired;
  logic [HIT_W-1:0]            hit_inc;
  logic [IDX_W-1:0]            rd_addr;
  logic [IDX_W-1:0]            wr_addr;
  logic                        act_we;
  logic                        hit_we;
  logic [EXT_W-1:0]            ri_ext;
  logic [EXT_W-1:0]            held_ext;

  assign eff_step = (step == '0) ? slcs_pkg::STEP_FALLBACK : step;
  assign nx_now   = {1'b0, cur_idx} + NX_W'(1);
  assign sum      = SUM_W'(start_freq) + SUM_W'(prod);
  assign nx_ok    = (nx < NX_W'(MAX_CHANNELS_P)) && (sum <= SUM_W'(end_freq));
  assign go       = scan_en && !awaiting && (start_freq <= end_freq) &&
                    ((now_ms - last_req_ms) >= {{(TIME_W-MS_W){1'b0}}, dwell});
  assign age      = now_ms - act_rd;
  assign expired  = age > {{(TIME_W-MS_W){1'b0}}, hang};
  assign hit_inc  = (hit_rd == slcs_pkg::HIT_MAX) ? hit_rd : hit_rd + HIT_W'(1);
  assign rd_addr  = lock ? held_idx : cur_idx;
  assign wr_addr  = cmd.clr_step ? clr_addr : rd_addr;
  assign act_we   = cmd.clr_step || (cmd.reply_step && loud);
  assign hit_we   = cmd.clr_step || (cmd.reply_step && loud && !lock);
  assign ri_ext   = EXT_W'(res_ri);
  assign held_ext = EXT_W'(held_idx);

  assign sts.awaiting = awaiting;
  assign sts.clr_last = (clr_addr == IDX_W'(MAX_CHANNELS_P - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      start_freq <= slcs_pkg::START_FREQ_RST;
      end_freq   <= slcs_pkg::END_FREQ_RST;
      step       <= slcs_pkg::STEP_RST;
      squelch    <= slcs_pkg::SQUELCH_RST;
      dwell      <= slcs_pkg::DWELL_RST;
      hang       <= slcs_pkg::HANG_RST;
      scan_en    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        slcs_pkg::CFG_START_FREQ: start_freq <= cfg_data;
        slcs_pkg::CFG_END_FREQ:   end_freq   <= cfg_data;
        slcs_pkg::CFG_STEP:       step       <= cfg_data[slcs_pkg::STEP_W-1:0];
        slcs_pkg::CFG_SQUELCH:    squelch    <= signed'(cfg_data[slcs_pkg::DBM_W-1:0]);
        slcs_pkg::CFG_DWELL:      dwell      <= cfg_data[MS_W-1:0];
        slcs_pkg::CFG_HANG:       hang       <= cfg_data[MS_W-1:0];
        slcs_pkg::CFG_ENABLE:     scan_en    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms      <= '0;
      last_req_ms <= '0;
      cur_idx     <= '0;
      cur_freq    <= slcs_pkg::START_FREQ_RST;
      lock        <= 1'b0;
      held_idx    <= '0;
      held_freq   <= '0;
      awaiting    <= 1'b0;
      clr_addr    <= '0;
    end else begin
      if (cmd.start_tick) now_ms <= now_ms + TIME_W'(1);
      if (cmd.start_rebuild) begin
        cur_idx   <= '0;
        cur_freq  <= start_freq;
        lock      <= 1'b0;
        held_idx  <= '0;
        held_freq <= '0;
        awaiting  <= 1'b0;
      end
      if (cmd.tick_step && go) begin
        last_req_ms <= now_ms;
        awaiting    <= 1'b1;
        if (!lock) begin
          cur_idx  <= nx_ok ? nx[IDX_W-1:0] : '0;
          cur_freq <= nx_ok ? sum[FREQ_W-1:0] : start_freq;
        end
      end
      if (cmd.reply_step) begin
        awaiting <= 1'b0;
        if (lock) begin
          if (!loud && expired) lock <= 1'b0;
        end else if (loud) begin
          lock      <= 1'b1;
          held_idx  <= cur_idx;
          held_freq <= cur_freq;
        end
      end
      if (cmd.clr_step) clr_addr <= sts.clr_last ? '0 : clr_addr + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_tick) begin
      nx   <= nx_now;
      prod <= PROD_W'(nx_now) * PROD_W'(eff_step);
    end
    if (cmd.accept) loud <= rssi_dbm > squelch;
  end

  always_ff @(posedge clk) begin
    act_rd <= act_mem[rd_addr];
    hit_rd <= hit_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (act_we) act_mem[wr_addr] <= cmd.clr_step ? '0 : now_ms;
  end

  always_ff @(posedge clk) begin
    if (hit_we) hit_mem[wr_addr] <= cmd.clr_step ? '0 : hit_inc;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_rv   <= 1'b0;
      res_ri   <= '0;
      res_rf   <= '0;
      res_ev   <= cmd.start_rebuild ? slcs_pkg::EV_REBUILT : slcs_pkg::EV_NONE;
      res_hits <= '0;
    end
    if (cmd.tick_step && go) begin
      res_rv <= 1'b1;
      if (lock) begin
        res_ri <= held_idx;
        res_rf <= held_freq;
      end else begin
        res_ri <= nx_ok ? nx[IDX_W-1:0] : '0;
        res_rf <= nx_ok ? sum[FREQ_W-1:0] : start_freq;
      end
    end
    if (cmd.reply_step) begin
      if (lock) begin
        if (loud) begin
          res_ev <= slcs_pkg::EV_REFRESH;
        end else if (expired) begin
          res_ev <= slcs_pkg::EV_RELEASED;
        end else begin
          res_ev <= slcs_pkg::EV_QUIET;
        end
        res_hits <= hit_rd;
      end else begin
        res_ev   <= loud ? slcs_pkg::EV_ACQUIRED : slcs_pkg::EV_QUIET;
        res_hits <= loud ? hit_inc : hit_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      request_valid   <= res_rv;
      request_index   <= ri_ext[slcs_pkg::OUT_IDX_W-1:0];
      request_freq_hz <= res_rf;
      is_locked       <= lock;
      locked_index    <= lock ? held_ext[slcs_pkg::OUT_IDX_W-1:0] : '0;
      event_code      <= res_ev;
      hit_total       <= res_hits;
    end
  end

endmodule

// ----- hdl/slcs_checker.sv -----
// Port-level checks for the squelch-lock channel scanner, bound to the top level.
// Depends on slcs_pkg and squelch_lock_channel_scanner.
module slcs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cmd_valid,
  input logic                           cmd_stall,
  input logic                           res_valid,
  input logic                           res_stall,
  input logic                           request_valid,
  input logic [slcs_pkg::OUT_IDX_W-1:0] request_index,
  input logic [slcs_pkg::FREQ_W-1:0]    request_freq_hz,
  input logic                           is_locked,
  input logic [slcs_pkg::OUT_IDX_W-1:0] locked_index,
  input logic [2:0]                     event_code,
  input logic [slcs_pkg::HIT_W-1:0]     hit_total
);

  // one item at a time: an accepted item blocks the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("item accepted while previous item still in work");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(event_code) && $stable(hit_total))
    else $error("stalled result changed");

  a_unlocked_index: assert property (@(posedge clk) disable iff (rst)
    res_valid && !is_locked |-> locked_index == '0)
    else $error("locked index set without lock");

  a_request_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && !request_valid |-> request_index == '0 && request_freq_hz == '0)
    else $error("request fields set without request");

  a_lock_events: assert property (@(posedge clk) disable iff (rst)
    res_valid && (event_code == slcs_pkg::EV_ACQUIRED || event_code == slcs_pkg::EV_REFRESH)
    |-> is_locked)
    else $error("lock event reported while unlocked");

endmodule

bind squelch_lock_channel_scanner slcs_checker u_slcs_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd_valid),
  .cmd_stall       (cmd_stall),
  .res_valid       (res_valid),
  .res_stall       (res_stall),
  .request_valid   (request_valid),
  .request_index   (request_index),
  .request_freq_hz (request_freq_hz),
  .is_locked       (is_locked),
  .locked_index    (locked_index),
  .event_code      (event_code),
  .hit_total       (hit_total)
);
